// ----- sv/sle_pkg.sv -----
// sle_pkg: command, status and operation types shared by the list engine modules
package sle_pkg;

	// fixed port widths
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned LEN_W   = 8;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned STAT_W  = 2;

	// command codes as they arrive on the input channel
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SORTED = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// what the cell row does this cycle
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_INSERT = 3'd1,
		OP_SORTED = 3'd2,
		OP_DELETE = 3'd3,
		OP_READ   = 3'd4
	} op_kind_t;

	// decoded command handed from the controller to the datapath
	typedef struct packed {
		op_kind_t kind;
		status_t  status;
		logic     grow;
		logic     shrink;
	} op_t;

endpackage

// ----- sv/sequential_list_engine.sv -----
// sequential_list_engine: bounded array list with positional and sorted insert, delete and read
//
// Usage: each input beat carries a command (insert at position, delete at position,
// sorted insert, read position), a 1-based position and a signed value. Each command
// gives exactly one output beat with the deleted or read element (zero otherwise),
// a status (ok, position out of range, list full) and the list length afterwards.
// Positions are checked against the current length; a failing command leaves the
// list untouched. The list lives in a row of CAPACITY cells; every cell compares
// against the new value and moves to its neighbor in the same cycle. The clock
// period is bounded by the parallel compare across all cells, its first-greater
// prefix and the read bus that gathers the addressed entry.
// Result: the result beat is valid in the cycle after the input beat is accepted.
// Throughput: one command per cycle while the output side takes beats.
// Stalls: the result sits in an output register; while it is stalled in_stall is
// raised, and a new command is taken in the cycle the waiting result is taken.
// Reset: the length and the output valid are cleared; entry contents are not
// cleared and are only read after being written.
module sequential_list_engine #(
	parameter int unsigned CAPACITY   = 128,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sle_pkg::CMD_W-1:0]           cmd,
	input  logic [sle_pkg::POS_W-1:0]           position,
	input  logic signed [sle_pkg::VALUE_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [sle_pkg::VALUE_W-1:0]  read_value,
	output logic [sle_pkg::STAT_W-1:0]          status,
	output logic [sle_pkg::LEN_W-1:0]           list_length
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = $clog2(CAPACITY);

	logic                          in_fire;
	logic                          out_valid_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_d;
	sle_pkg::op_t                  op;
	logic [IW-1:0]                 idx;
	logic signed [DATA_WIDTH-1:0]  ins_value;
	logic [DATA_WIDTH-1:0]         data_w [CAPACITY];
	logic [DATA_WIDTH-1:0]         rd_w   [CAPACITY];
	logic [CAPACITY-1:0]           gt_w;
	logic [CAPACITY-1:0]           below_w;
	logic                          none_gt;
	logic [DATA_WIDTH-1:0]         rd_bus;
	logic signed [sle_pkg::VALUE_W-1:0] read_value_q;
	logic [sle_pkg::STAT_W-1:0]    status_q;
	logic [sle_pkg::LEN_W-1:0]     length_q;

	// handshake: take a command when the output register is free or draining
	assign in_stall  = out_valid_q && out_stall;
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// value at storage width
	assign ins_value = DATA_WIDTH'(value);

	// command decode and range checks
	sle_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.fire    (in_fire),
		.cmd     (cmd),
		.position(position),
		.count   (count_q),
		.op      (op),
		.idx     (idx)
	);

	// row of cells with neighbor links and first-greater prefix
	assign none_gt = ~|gt_w;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CAPACITY-1:0] LOW_MASK = {CAPACITY{1'b1}} >> (CAPACITY - i);

		assign below_w[i] = |(gt_w & LOW_MASK);

		sle_cell #(
			.CAPACITY  (CAPACITY),
			.DATA_WIDTH(DATA_WIDTH),
			.IDX       (i)
		) u_cell (
			.clk       (clk),
			.kind      (op.kind),
			.idx       (idx),
			.count     (count_q),
			.ins_value (ins_value),
			.below     (below_w[i]),
			.none_gt   (none_gt),
			.left_data ((i == 0) ? data_w[i] : data_w[(i == 0) ? 0 : i - 1]),
			.right_data((i == CAPACITY - 1) ? data_w[i] :
				data_w[(i == CAPACITY - 1) ? i : i + 1]),
			.data      (data_w[i]),
			.gt        (gt_w[i]),
			.rd_data   (rd_w[i])
		);
	end

	// gather the addressed entry from the row
	always_comb begin
		rd_bus = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_bus = rd_bus | rd_w[k];
		end
	end

	// next length
	always_comb begin
		count_d = count_q;
		if (op.grow) begin
			count_d = count_q + 1'b1;
		end else if (op.shrink) begin
			count_d = count_q - 1'b1;
		end
	end

	// length and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_q <= op.status;
			length_q <= sle_pkg::LEN_W'(count_d);
			if (op.kind == sle_pkg::OP_DELETE || op.kind == sle_pkg::OP_READ) begin
				read_value_q <= sle_pkg::VALUE_W'($signed(rd_bus));
			end else begin
				read_value_q <= '0;
			end
		end
	end

	assign read_value  = read_value_q;
	assign status      = status_q;
	assign list_length = length_q;

	// length never exceeds the row
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length above capacity");

	// full status only when the list really is full
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op.status == sle_pkg::ST_FULL) |-> (count_q == CW'(CAPACITY)))
		else $error("full status on a list with room");

	// every accepted command yields a result beat next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted command without result");

	// length moves only on an accepted command
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> $stable(count_q))
		else $error("length changed without a command");

	// a failing command never changes the length
	a_fail_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && op.status != sle_pkg::ST_OK) |=> $stable(count_q))
		else $error("failing command changed the length");

endmodule

// ----- sv/sle_cell.sv -----
// sle_cell: one list entry that shifts with its neighbors and compares for sorted insert
module sle_cell #(
	parameter int unsigned CAPACITY   = 128,
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned IDX        = 0,
	localparam int unsigned CW = $clog2(CAPACITY + 1),
	localparam int unsigned IW = $clog2(CAPACITY)
) (
	input  logic                         clk,
	input  sle_pkg::op_kind_t            kind,
	input  logic [IW-1:0]                idx,
	input  logic [CW-1:0]                count,
	input  logic signed [DATA_WIDTH-1:0] ins_value,
	input  logic                         below,
	input  logic                         none_gt,
	input  logic [DATA_WIDTH-1:0]        left_data,
	input  logic [DATA_WIDTH-1:0]        right_data,
	output logic [DATA_WIDTH-1:0]        data,
	output logic                         gt,
	output logic [DATA_WIDTH-1:0]        rd_data
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  at_idx;
	logic                  after_idx;
	logic                  at_count;
	logic                  occupied;

	// position of this cell relative to the command index and the fill level
	assign at_idx    = (idx == IW'(IDX));
	assign after_idx = (IW'(IDX) > idx);
	assign at_count  = (count == CW'(IDX));
	assign occupied  = (CW'(IDX) < count);

	// live entry greater than the incoming value
	assign gt = occupied && ($signed(data_q) > ins_value);

	// contribute to the read bus only when addressed
	assign rd_data = at_idx ? data_q : '0;
	assign data    = data_q;

	// entry update: shift up, take the new value, shift down or hold
	always_ff @(posedge clk) begin
		case (kind)
			sle_pkg::OP_INSERT: begin
				if (after_idx) begin
					data_q <= left_data;
				end else if (at_idx) begin
					data_q <= ins_value;
				end
			end
			sle_pkg::OP_SORTED: begin
				if (below) begin
					data_q <= left_data;
				end else if (gt || (none_gt && at_count)) begin
					data_q <= ins_value;
				end
			end
			sle_pkg::OP_DELETE: begin
				if (at_idx || after_idx) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

// ----- sv/sle_ctrl.sv -----
// sle_ctrl: command decode, position range checks and status for the list engine
module sle_ctrl #(
	parameter int unsigned CAPACITY = 128,
	localparam int unsigned CW = $clog2(CAPACITY + 1),
	localparam int unsigned IW = $clog2(CAPACITY),
	localparam int unsigned XW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1
) (
	input  logic                      fire,
	input  logic [sle_pkg::CMD_W-1:0] cmd,
	input  logic [sle_pkg::POS_W-1:0] position,
	input  logic [CW-1:0]             count,
	output sle_pkg::op_t              op,
	output logic [IW-1:0]             idx
);

	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic          pos_nz;
	logic          ins_ok;
	logic          acc_ok;
	logic          full;

	// range checks on a common width
	assign pos_x  = XW'(position);
	assign cnt_x  = XW'(count);
	assign pos_nz = (position != '0);
	assign ins_ok = pos_nz && (pos_x <= cnt_x + 1'b1);
	assign acc_ok = pos_nz && (pos_x <= cnt_x);
	assign full   = (count == CW'(CAPACITY));

	// zero-based index, meaningful only when the position is in range
	assign idx = IW'(position - 1'b1);

	// decode into a row operation and a status
	always_comb begin
		op.kind   = sle_pkg::OP_NONE;
		op.status = sle_pkg::ST_OK;
		op.grow   = 1'b0;
		op.shrink = 1'b0;
		case (sle_pkg::cmd_t'(cmd))
			sle_pkg::CMD_INSERT: begin
				if (!ins_ok) begin
					op.status = sle_pkg::ST_RANGE;
				end else if (full) begin
					op.status = sle_pkg::ST_FULL;
				end else begin
					op.kind = sle_pkg::OP_INSERT;
					op.grow = 1'b1;
				end
			end
			sle_pkg::CMD_SORTED: begin
				if (full) begin
					op.status = sle_pkg::ST_FULL;
				end else begin
					op.kind = sle_pkg::OP_SORTED;
					op.grow = 1'b1;
				end
			end
			sle_pkg::CMD_DELETE: begin
				if (!acc_ok) begin
					op.status = sle_pkg::ST_RANGE;
				end else begin
					op.kind   = sle_pkg::OP_DELETE;
					op.shrink = 1'b1;
				end
			end
			sle_pkg::CMD_READ: begin
				if (!acc_ok) begin
					op.status = sle_pkg::ST_RANGE;
				end else begin
					op.kind = sle_pkg::OP_READ;
				end
			end
			default: begin
				op.status = sle_pkg::ST_RANGE;
			end
		endcase
		// nothing moves without an accepted beat
		if (!fire) begin
			op.kind   = sle_pkg::OP_NONE;
			op.grow   = 1'b0;
			op.shrink = 1'b0;
		end
	end

endmodule
